// ===== rtl/core/sfir_pkg.sv =====
// sfir_pkg: shared widths, sizes and the fixed low-pass coefficient table
// for the stereo 64-tap fir unit; no dependencies
package sfir_pkg;

    localparam int TAP_COUNT = 64;
    localparam int SLOT_W    = $clog2(TAP_COUNT);
    localparam int TAP_W     = SLOT_W + 1;
    localparam int SAMPLE_W  = 16;
    localparam int HIST_W    = 14;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = HIST_W + COEF_W;
    localparam int ACC_W     = PROD_W + SLOT_W;
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = ACC_W - FRAC_W;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    // symmetric q16 coefficients, tap 0 meets the newest sample
    function automatic logic signed [COEF_W-1:0] coef_lookup(input logic [SLOT_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            6'd0:    c = -16'sd11;
            6'd1:    c = 16'sd9;
            6'd2:    c = 16'sd46;
            6'd3:    c = 16'sd100;
            6'd4:    c = 16'sd143;
            6'd5:    c = 16'sd136;
            6'd6:    c = 16'sd55;
            6'd7:    c = -16'sd88;
            6'd8:    c = -16'sd227;
            6'd9:    c = -16'sd273;
            6'd10:   c = -16'sd159;
            6'd11:   c = 16'sd99;
            6'd12:   c = 16'sd384;
            6'd13:   c = 16'sd521;
            6'd14:   c = 16'sd369;
            6'd15:   c = -16'sd68;
            6'd16:   c = -16'sd600;
            6'd17:   c = -16'sd915;
            6'd18:   c = -16'sd743;
            6'd19:   c = -16'sd44;
            6'd20:   c = 16'sd901;
            6'd21:   c = 16'sd1567;
            6'd22:   c = 16'sd1438;
            6'd23:   c = 16'sd331;
            6'd24:   c = -16'sd1395;
            6'd25:   c = -16'sd2872;
            6'd26:   c = -16'sd3050;
            6'd27:   c = -16'sd1186;
            6'd28:   c = 16'sd2723;
            6'd29:   c = 16'sd7806;
            6'd30:   c = 16'sd12563;
            6'd31:   c = 16'sd15435;
            6'd32:   c = 16'sd15435;
            6'd33:   c = 16'sd12563;
            6'd34:   c = 16'sd7806;
            6'd35:   c = 16'sd2723;
            6'd36:   c = -16'sd1186;
            6'd37:   c = -16'sd3050;
            6'd38:   c = -16'sd2872;
            6'd39:   c = -16'sd1395;
            6'd40:   c = 16'sd331;
            6'd41:   c = 16'sd1438;
            6'd42:   c = 16'sd1567;
            6'd43:   c = 16'sd901;
            6'd44:   c = -16'sd44;
            6'd45:   c = -16'sd743;
            6'd46:   c = -16'sd915;
            6'd47:   c = -16'sd600;
            6'd48:   c = -16'sd68;
            6'd49:   c = 16'sd369;
            6'd50:   c = 16'sd521;
            6'd51:   c = 16'sd384;
            6'd52:   c = 16'sd99;
            6'd53:   c = -16'sd159;
            6'd54:   c = -16'sd273;
            6'd55:   c = -16'sd227;
            6'd56:   c = -16'sd88;
            6'd57:   c = 16'sd55;
            6'd58:   c = 16'sd136;
            6'd59:   c = 16'sd143;
            6'd60:   c = 16'sd100;
            6'd61:   c = 16'sd46;
            6'd62:   c = 16'sd9;
            6'd63:   c = -16'sd11;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/stereo_fir_filter_64tap_unit.sv =====
// stereo_fir_filter_64tap_unit: stereo 64-tap fir low-pass with bypass register
// depends on sfir_pkg (widths, coefficient table)
// one tap per cycle per channel through the single multiply-accumulate per channel
// a new pair waits on in_stall until the current result has been loaded into the output register
// reset: delay lines read as zero via per-slot valid bits, write slot and bypass cleared
// reset is asynchronous active low and takes effect at once, no clearing pass
module stereo_fir_filter_64tap_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0] left_raw,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0] right_raw,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sfir_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [sfir_pkg::SAMPLE_W-1:0] right_out,
    // bypass register write
    input  logic                                cfg_we,
    input  logic                                cfg_data
);
    import sfir_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // control state
    state_t                    state_reg, state_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;     // slot written by the next beat
    logic [SLOT_W-1:0]         base_reg, base_next;     // newest slot of the current pair
    logic [TAP_W-1:0]          tap_reg, tap_next;       // tap being issued, reaches TAP_COUNT
    logic                      bypass_reg, bypass_next;
    logic                      r_vld_reg;               // read stage holds a tap
    logic                      p_vld_reg;               // product stage holds a tap
    logic                      out_valid_reg, out_valid_next;
    logic [TAP_COUNT-1:0]      hvld_reg;                // slot written since reset

    // payload
    logic signed [HIST_W-1:0]  l_smp_reg, r_smp_reg;
    logic signed [HIST_W-1:0]  l_rd_reg, r_rd_reg;
    logic                      rd_hit_reg;
    logic signed [COEF_W-1:0]  coef_reg;
    logic signed [PROD_W-1:0]  l_prod_reg, r_prod_reg;
    logic signed [ACC_W-1:0]   l_acc_reg, r_acc_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg, right_out_reg;
    logic signed [SAMPLE_W-1:0] left_out_next, right_out_next;

    // history memories, one per channel
    logic signed [HIST_W-1:0]  l_mem [TAP_COUNT];
    logic signed [HIST_W-1:0]  r_mem [TAP_COUNT];

    logic                      in_acc;
    logic                      out_acc;
    logic                      issue;
    logic [SLOT_W-1:0]         rd_addr;
    logic signed [HIST_W-1:0]  l_shift, r_shift;
    logic signed [HIST_W-1:0]  l_tap, r_tap;
    logic signed [SUM_W-1:0]   l_sum, r_sum;
    logic signed [SAMPLE_W-1:0] l_sat, r_sat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    // floor shift by two is just the upper bits
    assign l_shift = left_raw[SAMPLE_W-1 -: HIST_W];
    assign r_shift = right_raw[SAMPLE_W-1 -: HIST_W];

    // tap k reads the sample k steps older than the newest one
    assign issue   = (state_reg == ST_RUN);
    assign rd_addr = base_reg - tap_reg[SLOT_W-1:0];

    // never-written slots read as zero
    assign l_tap = rd_hit_reg ? l_rd_reg : '0;
    assign r_tap = rd_hit_reg ? r_rd_reg : '0;

    // drop the q16 fraction (floor) and clamp to 16 bits
    assign l_sum = l_acc_reg[ACC_W-1:FRAC_W];
    assign r_sum = r_acc_reg[ACC_W-1:FRAC_W];
    assign l_sat = (l_sum > SAT_MAX) ? SAT_MAX[SAMPLE_W-1:0] :
                   (l_sum < SAT_MIN) ? SAT_MIN[SAMPLE_W-1:0] : l_sum[SAMPLE_W-1:0];
    assign r_sat = (r_sum > SAT_MAX) ? SAT_MAX[SAMPLE_W-1:0] :
                   (r_sum < SAT_MIN) ? SAT_MIN[SAMPLE_W-1:0] : r_sum[SAMPLE_W-1:0];

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        base_next      = base_reg;
        tap_next       = tap_reg;
        bypass_next    = bypass_reg;
        out_valid_next = out_valid_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;

        if (cfg_we)
        begin
            bypass_next = cfg_data;
        end

        // output beat taken
        if (out_acc)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    base_next  = slot_reg;
                    slot_next  = slot_reg + 1'b1;
                    tap_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                tap_next = tap_reg + 1'b1;
                if (tap_reg == TAP_W'(TAP_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait until the last product has been summed
                if (!r_vld_reg && !p_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // output register free or emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (bypass_reg)
                    begin
                        left_out_next  = SAMPLE_W'(l_smp_reg);
                        right_out_next = SAMPLE_W'(r_smp_reg);
                    end
                    else
                    begin
                        left_out_next  = l_sat;
                        right_out_next = r_sat;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            base_reg      <= '0;
            tap_reg       <= '0;
            bypass_reg    <= 1'b0;
            r_vld_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            hvld_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            base_reg      <= base_next;
            tap_reg       <= tap_next;
            bypass_reg    <= bypass_next;
            r_vld_reg     <= issue;
            p_vld_reg     <= r_vld_reg;
            out_valid_reg <= out_valid_next;
            if (in_acc)
            begin
                hvld_reg[slot_reg] <= 1'b1;
            end
        end
    end

    // history memories: write on the accepted beat, registered read per tap
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            l_mem[slot_reg] <= l_shift;
            r_mem[slot_reg] <= r_shift;
        end
        l_rd_reg <= l_mem[rd_addr];
        r_rd_reg <= r_mem[rd_addr];
    end

    // mac datapath: read, multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            l_smp_reg <= l_shift;
            r_smp_reg <= r_shift;
        end
        rd_hit_reg    <= hvld_reg[rd_addr];
        coef_reg      <= coef_lookup(tap_reg[SLOT_W-1:0]);
        l_prod_reg    <= l_tap * coef_reg;
        r_prod_reg    <= r_tap * coef_reg;
        if (in_acc)
        begin
            l_acc_reg <= '0;
            r_acc_reg <= '0;
        end
        else if (p_vld_reg)
        begin
            l_acc_reg <= l_acc_reg + ACC_W'(l_prod_reg);
            r_acc_reg <= r_acc_reg + ACC_W'(r_prod_reg);
        end
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    // an accepted beat makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after an accepted input beat");

    // mac pipeline only carries taps while a pair is in work
    a_pipe_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (r_vld_reg || p_vld_reg) |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("mac pipeline active outside a filter pass");

    // a result is loaded only on leaving the done state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result beat raised outside the done state");

    // tap counter never runs past TAP_COUNT
    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg <= TAP_W'(TAP_COUNT))
        else $error("tap counter out of range");

endmodule
